// ===== hw/rtl/battery_charge_and_runtime_estimator_defines.svh =====
// ----------------------------------------------------------------------------
// Battery estimator assertion macros
// Shared assertion forms; the asserting scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_AND_RUNTIME_ESTIMATOR_DEFINES_SVH
`define BATTERY_CHARGE_AND_RUNTIME_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define BCE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bce assertion failed");

// next-cycle implication
`define BCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bce assertion failed");

`endif

// ===== hw/rtl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Types, constants and table functions of the battery estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bce_pkg;

	localparam int DIV_BITS = 24;
	localparam int NSTG     = DIV_BITS + 2;

	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [0:0] REG_RESIST   = 1'b1;

	localparam logic [15:0] CAPACITY_RST = 16'd1000;
	localparam logic [9:0]  RESIST_RST   = 10'd100;

	localparam logic signed [27:0] OCV_BASE = 28'sd3400000;
	localparam logic signed [27:0] OCV_TOP  = 28'sd4200000;
	localparam logic [19:0]        SEG_STEP = 20'd100000;

	// floor(x / 3125) for x < 2^24, and floor(z / 375) for z < 2^24
	localparam logic [24:0] RECIP_3125 = 25'd21990233;
	localparam int          SHIFT_3125 = 36;
	localparam logic [24:0] RECIP_375  = 25'd22906493;
	localparam int          SHIFT_375  = 33;

	localparam logic [14:0] PCT_MAX_Q8  = 15'd25600;
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	localparam logic [23:0] RUNTIME_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [12:0]        voltage_mv;
		logic signed [15:0] current_ma;
		logic signed [15:0] power_mw;
		logic signed [7:0]  temperature_c;
	} sample_t;

	typedef struct packed {
		logic [6:0]  charge_percent;
		logic        is_charging;
		logic [23:0] runtime_hours_q8;
		logic        runtime_valid;
	} result_t;

	typedef logic [NSTG:1] adv_t;

	// discharge curve points in whole percent, 3.4 V to 4.2 V
	function automatic logic [6:0] curve_pct(input logic [3:0] idx);
		logic [6:0] p;
		case (idx)
			4'd0: p = 7'd5;
			4'd1: p = 7'd10;
			4'd2: p = 7'd20;
			4'd3: p = 7'd40;
			4'd4: p = 7'd60;
			4'd5: p = 7'd75;
			4'd6: p = 7'd85;
			4'd7: p = 7'd95;
			default: p = 7'd100;
		endcase
		return p;
	endfunction

	// temperature factor numerator, factor = num / 3000
	function automatic logic [11:0] temp_num(input logic signed [7:0] t);
		int n;
		n = int'(t);
		if (n < 0)
			n = 2100 - 15 * n;
		else if (n < 10)
			n = 2550 + 15 * n;
		else if (n > 45)
			n = 3000 - 20 * (n - 45);
		else
			n = 3000;
		return 12'(n);
	endfunction

endpackage

// ===== hw/rtl/bce_if.sv =====
// ----------------------------------------------------------------------------
// bce_if
// Valid/ready channels for readings and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface bce_in_if import bce_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bce_out_if import bce_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/battery_charge_and_runtime_estimator.sv =====
// Depth: set by the 24-stage runtime divider, which the charge path matches.
// Throughput: one reading per cycle while the output is not stalled.
// Stall: each stage holds while the stage after it is full and stalled,
//   so bubbles collapse and the input keeps flowing into empty stages.
// Reset: arst_n clears all stage valid bits and loads capacity 1000 mAh
//   and resistance 100 mOhm; stage payload registers are not reset.
// ----------------------------------------------------------------------------
// battery_charge_and_runtime_estimator
// Voltage-based Li-ion state of charge and runtime estimate, fully pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module battery_charge_and_runtime_estimator import bce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	bce_in_if.sink      sample,
	bce_out_if.source   result
);

	logic [15:0] capacity_q;
	logic [9:0]  resist_q;

	adv_t        adv;
	logic [NSTG:1] vld_q;

	logic [22:0]        vmv_uv;
	logic signed [26:0] ir_uv;

	logic signed [27:0] ocv_s1;
	logic [11:0]        tnum_s1;
	logic [28:0]        prod_s1;
	logic [24:0]        den_s1;
	logic               chg_s1;
	logic               rtv_s1;

	logic [6:0]  pct;
	logic [23:0] runtime;
	logic        rt_valid;
	logic        charging;

	// configuration registers, written only while the pipe is empty: up to user
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			resist_q   <= RESIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data;
				REG_RESIST:   resist_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances too
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || result.ready;
		for (int k = NSTG - 1; k >= 1; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	assign sample.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1])
				vld_q[1] <= sample.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: open-circuit voltage in uV, runtime numerator and divisor
	assign vmv_uv = sample.data.voltage_mv * 10'd1000;
	assign ir_uv  = sample.data.current_ma * $signed({1'b0, resist_q});

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ocv_s1  <= $signed({5'b00000, vmv_uv}) + 28'(ir_uv);
			tnum_s1 <= temp_num(sample.data.temperature_c);
			prod_s1 <= capacity_q * sample.data.voltage_mv;
			den_s1  <= sample.data.power_mw[14:0] * 10'd1000;
			chg_s1  <= sample.data.current_ma[15];
			rtv_s1  <= !sample.data.current_ma[15] && !sample.data.power_mw[15]
				&& (sample.data.power_mw != 16'sd0);
		end
	end

	bce_soc u_soc (
		.clk     (clk),
		.adv     (adv),
		.ocv_s1  (ocv_s1),
		.tnum_s1 (tnum_s1),
		.pct     (pct)
	);

	bce_div u_div (
		.clk      (clk),
		.adv      (adv),
		.prod_s1  (prod_s1),
		.den_s1   (den_s1),
		.chg_s1   (chg_s1),
		.rtv_s1   (rtv_s1),
		.runtime  (runtime),
		.rt_valid (rt_valid),
		.charging (charging)
	);

	// last stage is the output register
	assign result.valid                 = vld_q[NSTG];
	assign result.data.charge_percent   = pct;
	assign result.data.is_charging      = charging;
	assign result.data.runtime_hours_q8 = runtime;
	assign result.data.runtime_valid    = rt_valid;

endmodule

// ===== hw/rtl/bce_soc.sv =====
// ----------------------------------------------------------------------------
// bce_soc
// Charge path: curve interpolation, temperature scaling, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bce_soc import bce_pkg::*; (
	input  logic                clk,
	input  adv_t                adv,
	input  logic signed [27:0]  ocv_s1,
	input  logic [11:0]         tnum_s1,
	output logic [6:0]          pct
);

	logic [19:0] off;
	logic [2:0]  seg;
	logic [19:0] seg_base;
	logic [16:0] frac;
	logic [6:0]  lo_pct;
	logic [4:0]  dlt;
	logic [23:0] xprod;
	logic [48:0] qprod;
	logic [12:0] qint;
	logic [26:0] yprod;
	logic [48:0] wprod;
	logic [15:0] wq;

	logic [23:0] x_s2;
	logic [6:0]  base_s2;
	logic        top_s2, bot_s2;
	logic [11:0] tnum_s2, tnum_s3;
	logic [14:0] pq8_s3;
	logic [23:0] z_s4;
	logic [6:0]  pct_s [5:NSTG];

	// stage 2: segment, fraction and scaled slope term
	always_comb begin
		off = 20'(ocv_s1 - OCV_BASE);
		seg = '0;
		for (int j = 1; j <= 7; j++) begin
			if (off >= 20'(j * 100000))
				seg = 3'(j);
		end
		seg_base = 20'(seg * SEG_STEP);
		frac     = 17'(off - seg_base);
		lo_pct   = curve_pct({1'b0, seg});
		dlt      = 5'(curve_pct({1'b0, seg} + 4'd1) - lo_pct);
		xprod    = {21'(dlt * frac), 3'b000};
	end

	// stage 3: divide by 3125 through the reciprocal
	assign qprod = x_s2 * RECIP_3125;
	assign qint  = qprod[SHIFT_3125 +: 13];

	// stage 4: apply temperature numerator, shift right by 3
	assign yprod = pq8_s3 * tnum_s3;

	// stage 5: divide by 375 through the reciprocal, clamp
	assign wprod = z_s4 * RECIP_375;
	assign wq    = wprod[SHIFT_375 +: 16];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			x_s2    <= xprod;
			base_s2 <= lo_pct;
			top_s2  <= (ocv_s1 >= OCV_TOP);
			bot_s2  <= (ocv_s1 < OCV_BASE);
			tnum_s2 <= tnum_s1;
		end
		if (adv[3]) begin
			if (top_s2)
				pq8_s3 <= PCT_MAX_Q8;
			else if (bot_s2)
				pq8_s3 <= '0;
			else
				pq8_s3 <= {base_s2, 8'h00} + {2'b00, qint};
			tnum_s3 <= tnum_s2;
		end
		if (adv[4])
			z_s4 <= yprod[26:3];
		if (adv[5])
			pct_s[5] <= (wq > {1'b0, PCT_MAX_Q8}) ? PCT_MAX : wq[14:8];
		// hold the percent until the runtime quotient is ready
		for (int k = 6; k <= NSTG; k++) begin
			if (adv[k])
				pct_s[k] <= pct_s[k-1];
		end
	end

	assign pct = pct_s[NSTG];

endmodule

// ===== hw/rtl/bce_div.sv =====
// ----------------------------------------------------------------------------
// bce_div
// Runtime path: pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bce_div import bce_pkg::*; (
	input  logic        clk,
	input  adv_t        adv,
	input  logic [28:0] prod_s1,
	input  logic [24:0] den_s1,
	input  logic        chg_s1,
	input  logic        rtv_s1,
	output logic [23:0] runtime,
	output logic        rt_valid,
	output logic        charging
);

	logic [36:0] dvd;
	logic [48:0] den_sh;

	logic [24:0]         rem_s  [2:NSTG];
	logic [DIV_BITS-1:0] quo_s  [2:NSTG];
	logic [DIV_BITS-1:0] low_s  [2:NSTG];
	logic [24:0]         den_s  [2:NSTG];
	logic                sat_s  [2:NSTG];
	logic                chg_s  [2:NSTG];
	logic                rtv_s  [2:NSTG];
	logic [25:0]         trial  [3:NSTG];
	logic [25:0]         diff   [3:NSTG];

	assign dvd    = {prod_s1, 8'h00};
	assign den_sh = {den_s1, 24'h000000};

	always_comb begin
		for (int k = 3; k <= NSTG; k++) begin
			trial[k] = {rem_s[k-1], low_s[k-1][NSTG-k]};
			diff[k]  = trial[k] - {1'b0, den_s[k-1]};
		end
	end

	always_ff @(posedge clk) begin
		// stage 2: detect saturation, seed the remainder with the top bits
		if (adv[2]) begin
			sat_s[2] <= ({12'h000, dvd} >= den_sh);
			rem_s[2] <= {12'h000, dvd[36:24]};
			low_s[2] <= dvd[23:0];
			quo_s[2] <= '0;
			den_s[2] <= den_s1;
			chg_s[2] <= chg_s1;
			rtv_s[2] <= rtv_s1;
		end
		for (int k = 3; k <= NSTG; k++) begin
			if (adv[k]) begin
				if (trial[k] >= {1'b0, den_s[k-1]}) begin
					rem_s[k] <= diff[k][24:0];
					quo_s[k] <= quo_s[k-1] | (DIV_BITS'(1) << (NSTG - k));
				end else begin
					rem_s[k] <= trial[k][24:0];
					quo_s[k] <= quo_s[k-1];
				end
				low_s[k] <= low_s[k-1];
				den_s[k] <= den_s[k-1];
				sat_s[k] <= sat_s[k-1];
				chg_s[k] <= chg_s[k-1];
				rtv_s[k] <= rtv_s[k-1];
			end
		end
	end

	assign runtime  = !rtv_s[NSTG] ? '0 : (sat_s[NSTG] ? RUNTIME_MAX : quo_s[NSTG]);
	assign rt_valid = rtv_s[NSTG];
	assign charging = chg_s[NSTG];

endmodule

// ===== hw/rtl/bce_chk.sv =====
// ----------------------------------------------------------------------------
// bce_chk
// Port-level checks on the estimator result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_charge_and_runtime_estimator_defines.svh"
module bce_chk import bce_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	`BCE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`BCE_ASSERT_IMPL(a_excl, out_valid, !(out_data.runtime_valid && out_data.is_charging))
	`BCE_ASSERT_IMPL(a_zero, out_valid && !out_data.runtime_valid, out_data.runtime_hours_q8 == '0)
	`BCE_ASSERT_IMPL(a_pct, out_valid, out_data.charge_percent <= PCT_MAX)

endmodule

bind battery_charge_and_runtime_estimator bce_chk u_bce_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery estimator regression bench
// Sends directed and random sensor readings through the estimator under
// several capacity and resistance settings, with random gaps on the input
// and random stalls on the output. Every result is compared field by field
// with a hand-typed value or the in-bench fixed-point estimate model.
// ----------------------------------------------------------------------------
module tb;
	import bce_pkg::*;

	// One directed reading. Where want_known is set, the expected result is
	// typed in by hand instead of taken from the estimate model.
	typedef struct {
		int      volt;
		int      cur;
		int      pwr;
		int      temp;
		bit      want_known;
		result_t want;
	} reading_row_t;

	localparam int N_ROWS       = 24;
	localparam int N_PHASES     = 6;
	localparam int PHASE_ITEMS  = 310;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	bce_in_if  sample_if ();
	bce_out_if result_if ();

	// Local copy of the two configuration registers.
	logic [15:0] cap_mah;
	logic [9:0]  res_mohm;

	result_t     pending_results[$];
	int          errors;
	bit          out_burst;

	reading_row_t rows[N_ROWS];

	battery_charge_and_runtime_estimator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if.sink),
		.result    (result_if.source)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Expected charge and runtime for one reading at the current settings.
	function automatic result_t estimate(sample_t s);
		int     curve[9] = '{5, 10, 20, 40, 60, 75, 85, 95, 100};
		longint ocv_uv;
		longint off;
		longint seg;
		longint frac;
		longint pct_q8;
		longint scaled;
		longint runtime;
		int     t;
		int     factor_num;
		result_t r;
		ocv_uv = longint'(s.voltage_mv) * 1000 + longint'(s.current_ma) * longint'(res_mohm);
		// look up the discharge curve in Q8.8, floored interpolation
		if (ocv_uv >= 4200000)
			pct_q8 = 25600;
		else if (ocv_uv < 3400000)
			pct_q8 = 0;
		else begin
			off = ocv_uv - 3400000;
			seg = off / 100000;
			if (seg > 7)
				seg = 7;
			frac = off - seg * 100000;
			pct_q8 = curve[seg] * 256
				+ ((curve[seg + 1] - curve[seg]) * 256 * frac) / 100000;
		end
		// piecewise temperature factor, numerator over 3000
		t = int'(s.temperature_c);
		if (t < 0)
			factor_num = 2100 - 15 * t;
		else if (t < 10)
			factor_num = 2550 + 15 * t;
		else if (t > 45)
			factor_num = 3000 - 20 * (t - 45);
		else
			factor_num = 3000;
		scaled = (pct_q8 * factor_num) / 3000;
		if (scaled > 25600)
			scaled = 25600;
		r.charge_percent = 7'(scaled >> 8);
		r.is_charging    = s.current_ma < 0;
		r.runtime_valid  = !r.is_charging && s.power_mw > 0;
		runtime = 0;
		if (r.runtime_valid) begin
			runtime = (longint'(cap_mah) * longint'(s.voltage_mv) * 256)
				/ (longint'(s.power_mw) * 1000);
			if (runtime > 64'd16777215)
				runtime = 16777215;
		end
		r.runtime_hours_q8 = 24'(runtime);
		return r;
	endfunction

	task automatic report_mismatch(string field, longint want, longint got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		errors++;
	endtask

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(logic [0:0] idx, logic [15:0] value);
		// hold off until the pipe has drained
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		if (idx == REG_CAPACITY)
			cap_mah = value;
		else
			res_mohm = value[9:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Present one reading and hold it until the transaction completes.
	task automatic send_reading(sample_t s, bit want_known, result_t want, bit no_gap);
		int idle;
		idle = no_gap ? 0 : gap_len();
		if (idle > 0) begin
			sample_if.valid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		sample_if.valid = 1'b1;
		sample_if.data  = s;
		forever begin
			@(posedge clk);
			if (sample_if.ready)
				break;
		end
		pending_results.push_back(want_known ? want : estimate(s));
		@(negedge clk);
		sample_if.valid = 1'b0;
	endtask

	// Random reading; most sit near the curve so the interpolation is exercised.
	function automatic sample_t random_reading();
		sample_t s;
		s.voltage_mv = ($urandom_range(0, 3) != 0) ? 13'($urandom_range(3250, 4350))
			: 13'($urandom);
		s.current_ma = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3000) - 1000)
			: 16'($urandom);
		case ($urandom_range(0, 5))
			0: s.power_mw = 16'($urandom);
			1: s.power_mw = 16'($urandom_range(1, 20));
			default: s.power_mw = 16'($urandom_range(1, 32767));
		endcase
		s.temperature_c = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 100) - 30)
			: 8'($urandom);
		return s;
	endfunction

	// Output side: random stalls with no-stall stretches.
	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_burst)
				result_if.ready = 1'b1;
			else if (stall_left > 0) begin
				result_if.ready = 1'b0;
				stall_left--;
			end else begin
				stall_left = gap_len();
				result_if.ready = (stall_left == 0);
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with no reading outstanding", $time);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result_if.data.charge_percent !== want.charge_percent)
					report_mismatch("charge_percent", want.charge_percent,
						result_if.data.charge_percent);
				if (result_if.data.is_charging !== want.is_charging)
					report_mismatch("is_charging", want.is_charging,
						result_if.data.is_charging);
				if (result_if.data.runtime_hours_q8 !== want.runtime_hours_q8)
					report_mismatch("runtime_hours_q8", want.runtime_hours_q8,
						result_if.data.runtime_hours_q8);
				if (result_if.data.runtime_valid !== want.runtime_valid)
					report_mismatch("runtime_valid", want.runtime_valid,
						result_if.data.runtime_valid);
			end
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		#5ms;
		$display("battery_charge_and_runtime_estimator regression: fail");
		$finish;
	end

	initial begin
		sample_t     s;
		logic [15:0] cap_sel[N_PHASES];
		logic [15:0] res_sel[N_PHASES];
		errors          = 0;
		out_burst       = 1'b0;
		cap_mah         = CAPACITY_RST;
		res_mohm        = RESIST_RST;
		cfg_we          = 1'b0;
		cfg_index       = REG_CAPACITY;
		cfg_data        = '0;
		sample_if.valid = 1'b0;
		sample_if.data  = '0;

		// Directed readings: field extremes, curve edges, temperature bends,
		// charging and non-positive power.
		rows = '{
			'{0, 0, 0, 25, 1'b1, '{7'd0, 1'b0, 24'd0, 1'b0}},
			'{4200, 0, 1000, 25, 1'b1, '{7'd100, 1'b0, 24'd1075, 1'b1}},
			'{8191, -1, 100, 25, 1'b1, '{7'd100, 1'b1, 24'd0, 1'b0}},
			'{4200, 0, 0, 25, 1'b1, '{7'd100, 1'b0, 24'd0, 1'b0}},
			'{3400, 0, 1, 25, 1'b0, '0},
			'{3399, 0, 32767, 25, 1'b0, '0},
			'{4199, 0, 500, 25, 1'b0, '0},
			'{3750, 0, -32768, 25, 1'b0, '0},
			'{3650, 32767, 2000, 25, 1'b0, '0},
			'{3900, -32768, 2000, 25, 1'b0, '0},
			'{8191, 0, 1, 25, 1'b0, '0},
			'{3850, 500, 1500, -128, 1'b0, '0},
			'{3850, 500, 1500, -1, 1'b0, '0},
			'{3850, 500, 1500, 0, 1'b0, '0},
			'{3850, 500, 1500, 9, 1'b0, '0},
			'{3850, 500, 1500, 10, 1'b0, '0},
			'{3850, 500, 1500, 45, 1'b0, '0},
			'{3850, 500, 1500, 46, 1'b0, '0},
			'{3850, 500, 1500, 127, 1'b0, '0},
			'{4150, 0, 800, -30, 1'b0, '0},
			'{4000, 0, -1, -40, 1'b0, '0},
			'{3550, 200, 3000, 5, 1'b0, '0},
			'{3300, 1000, 700, 20, 1'b0, '0},
			'{4250, 0, 1, 127, 1'b0, '0}
		};

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass at the reset settings.
		foreach (rows[i]) begin
			s.voltage_mv    = 13'(rows[i].volt);
			s.current_ma    = 16'(rows[i].cur);
			s.power_mw      = 16'(rows[i].pwr);
			s.temperature_c = 8'(rows[i].temp);
			send_reading(s, rows[i].want_known, rows[i].want, 1'b0);
		end

		// Settings per phase: reset values, both extremes, then random ones.
		cap_sel = '{CAPACITY_RST, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom),
			16'($urandom_range(100, 5000))};
		res_sel = '{RESIST_RST, 16'd0, 16'd1023, 16'($urandom), 16'($urandom),
			16'($urandom_range(20, 300))};

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph > 0) begin
				write_reg(REG_CAPACITY, cap_sel[ph]);
				write_reg(REG_RESIST, res_sel[ph]);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// every so often run a stretch with no idling on either side
				if (n % 60 == 0)
					out_burst = ($urandom_range(0, 2) == 0);
				send_reading(random_reading(), 1'b0, '0, out_burst);
			end
			out_burst = 1'b0;
		end

		// drain, then allow the pipeline latency for stray results
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("battery_charge_and_runtime_estimator regression: pass");
		else
			$display("battery_charge_and_runtime_estimator regression: fail");
		$finish;
	end

endmodule
